// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
    // Products and sums stay exact in this width.
    localparam int WIDE_WIDTH    = 2 * OPERAND_WIDTH + 1;
    localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int RES_NUM_WIDTH = 33;
    localparam int RES_DEN_WIDTH = 31;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    // One classified job: magnitudes and the result sign.
    typedef struct packed {
        logic [MAG_WIDTH-1:0] num_mag;
        logic [MAG_WIDTH-1:0] den_mag;
        logic                 neg;
    } t_job;
endpackage

// ===== src/rational_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Reduced add, subtract, multiply and divide of two fractions.
// ----------------------------------------------------------------------------
// In the back end a result runs a binary gcd, one step per cycle on the
// 32-bit magnitudes (every subtraction is followed by a halving), then
// bit-serial division of numerator and denominator by the gcd. The front end
// registers the products, then the sum and sign split, and buffers two jobs,
// so new items transfer in while the back end works, and a finished result
// waits in its own register so the back end can take the next job. Zero
// results come out as 0/1, and a zero divisor or zero denominator gives 0/1
// with o_div_zero set.
module rational_arith_unit_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [1:0]                            i_func,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]         i_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]         i_b_den,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] o_res_num,
    output logic [rau_pkg::RES_DEN_WIDTH-1:0]     o_res_den,
    output logic                                  o_div_zero
);
    import rau_pkg::*;

    logic job_valid, job_take;
    t_job job;

    rau_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_func, .i_a_num, .i_a_den,
        .i_b_num, .i_b_den, .o_job_valid(job_valid), .o_job(job),
        .i_job_take(job_take)
    );

    rau_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job),
        .o_job_take(job_take), .empty, .pop, .o_res_num, .o_res_den,
        .o_div_zero
    );
endmodule

// ===== src/rau_front.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts operand pairs, registers the cross products, then sum and sign split,
// and writes the classified job into a short queue toward the back end.
// ----------------------------------------------------------------------------
module rau_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_func,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]     i_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]     i_b_den,
    output logic                              o_job_valid,
    output rau_pkg::t_job                     o_job,
    input  logic                              i_job_take
);
    import rau_pkg::*;

    localparam int PW = 2 * OPERAND_WIDTH;

    // Stage 1: registered products.
    logic              r_s1_valid;
    t_func             r_func;
    logic signed [PW-1:0] r_p0, r_p1, r_dp;

    // Stage 2 output register, held until it enters the queue.
    logic              r_s2_valid;
    t_job              r_s2;

    // Queue.
    t_job              r_q [QUEUE_DEPTH];
    logic [QUEUE_AW:0] r_cnt;
    logic [QUEUE_AW-1:0] r_wp, r_rp;

    logic              s2_move, q_wr, q_rd, s1_move;
    logic signed [PW-1:0] an, bn, ad, bd;
    logic signed [WIDE_WIDTH-1:0] n_n, n_d;

    assign q_wr    = r_s2_valid && (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_rd    = i_job_take && (r_cnt != '0);
    assign s2_move = !r_s2_valid || q_wr;
    assign s1_move = !r_s1_valid || s2_move;
    assign full    = !s1_move;

    // Operands widened to the product width so every product is exact.
    assign an = PW'(i_a_num);
    assign bn = PW'(i_b_num);
    assign ad = PW'(i_a_den);
    assign bd = PW'(i_b_den);

    // Stage 1: the products that the operation needs, three for add and subtract, two otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= push;
        end
        if (s1_move && push) begin
            r_func <= t_func'(i_func);
            case (t_func'(i_func))
                FUNC_MUL: begin
                    r_p0 <= an * bn;
                    r_p1 <= '0;
                    r_dp <= ad * bd;
                end
                FUNC_DIV: begin
                    r_p0 <= an * bd;
                    r_p1 <= '0;
                    r_dp <= ad * bn;
                end
                default: begin
                    r_p0 <= an * bd;
                    r_p1 <= bn * ad;
                    r_dp <= ad * bd;
                end
            endcase
        end
    end

    // Stage 2: sum or difference, then sign and magnitude split.
    always_comb begin
        case (r_func)
            FUNC_ADD: n_n = WIDE_WIDTH'(r_p0) + WIDE_WIDTH'(r_p1);
            FUNC_SUB: n_n = WIDE_WIDTH'(r_p0) - WIDE_WIDTH'(r_p1);
            default:  n_n = WIDE_WIDTH'(r_p0);
        endcase
        n_d = WIDE_WIDTH'(r_dp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_move) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_move && r_s1_valid) begin
            r_s2.neg     <= n_n[WIDE_WIDTH-1] ^ n_d[WIDE_WIDTH-1];
            r_s2.num_mag <= MAG_WIDTH'(n_n[WIDE_WIDTH-1] ? -n_n : n_n);
            r_s2.den_mag <= MAG_WIDTH'(n_d[WIDE_WIDTH-1] ? -n_d : n_d);
        end
    end

    // Queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (q_wr) r_wp <= r_wp + 1'b1;
            if (q_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(q_wr) - (QUEUE_AW+1)'(q_rd);
        end
        if (q_wr) r_q[r_wp] <= r_s2;
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !q_wr) |=> r_s2_valid && $stable(r_s2))
        else $error("stalled job lost");
    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !q_wr)
        else $error("write into full queue");
`endif
endmodule

// ===== src/rau_back.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Binary gcd with one step per cycle, then two restoring divisions by the gcd
// run side by side one quotient bit per cycle, and a result register.
// ----------------------------------------------------------------------------
module rau_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  rau_pkg::t_job                 i_job,
    output logic                          o_job_take,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] o_res_num,
    output logic [rau_pkg::RES_DEN_WIDTH-1:0] o_res_den,
    output logic                          o_div_zero
);
    import rau_pkg::*;

    localparam int MW = MAG_WIDTH;
    localparam int SW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    typedef enum logic [2:0] {
        ST_IDLE, ST_GCD, ST_FIX, ST_DIV, ST_DONE
    } t_state;

    t_state         r_state;
    logic [MW-1:0]  r_u, r_v, r_nm, r_dm, r_qn, r_qd, r_rn, r_rd;
    logic [SW-1:0]  r_sh;
    logic [CW-1:0]  r_bit;
    logic           r_neg;
    logic           r_out_valid;
    logic signed [RES_NUM_WIDTH-1:0] r_fin_num;
    logic [RES_DEN_WIDTH-1:0] r_fin_den;
    logic           r_fin_dz;
    logic signed [RES_NUM_WIDTH-1:0] r_res_num;
    logic [RES_DEN_WIDTH-1:0] r_res_den;
    logic           r_div_zero;

    logic [MW:0]    tn, td;
    logic [MW-1:0]  g, diff_uv, qn_last;
    logic           out_load;

    assign o_job_take = (r_state == ST_IDLE) && i_job_valid;
    assign g          = r_u << r_sh;
    assign diff_uv    = (r_u > r_v) ? r_u - r_v : r_v - r_u;
    assign tn         = {r_rn, r_nm[r_bit]} - {1'b0, g};
    assign td         = {r_rd, r_dm[r_bit]} - {1'b0, g};
    assign qn_last    = {r_qn[MW-2:0], !tn[MW]};
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || pop);

    // Sequencer. A finished job waits in ST_DONE until the result register frees.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_nm  <= i_job.num_mag;
                        r_dm  <= i_job.den_mag;
                        r_u   <= i_job.num_mag;
                        r_v   <= i_job.den_mag;
                        r_neg <= i_job.neg;
                        r_sh  <= '0;
                        if (i_job.den_mag == '0) begin
                            r_fin_num <= '0;
                            r_fin_den <= RES_DEN_WIDTH'(1);
                            r_fin_dz  <= 1'b1;
                            r_state   <= ST_DONE;
                        end else if (i_job.num_mag == '0) begin
                            r_fin_num <= '0;
                            r_fin_den <= RES_DEN_WIDTH'(1);
                            r_fin_dz  <= 1'b0;
                            r_state   <= ST_DONE;
                        end else begin
                            r_state <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    // Stein step: strip common twos, then odd halves and differences.
                    if (r_u == r_v) begin
                        r_state <= ST_FIX;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u  <= r_u >> 1;
                        r_v  <= r_v >> 1;
                        r_sh <= r_sh + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= diff_uv;
                    end else begin
                        r_v <= diff_uv;
                    end
                end
                ST_FIX: begin
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_qn  <= '0;
                    r_qd  <= '0;
                    r_bit <= CW'(MW - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // One quotient bit of each division.
                    if (!tn[MW]) begin
                        r_rn <= tn[MW-1:0];
                    end else begin
                        r_rn <= {r_rn[MW-2:0], r_nm[r_bit]};
                    end
                    if (!td[MW]) begin
                        r_rd <= td[MW-1:0];
                    end else begin
                        r_rd <= {r_rd[MW-2:0], r_dm[r_bit]};
                    end
                    r_qn <= qn_last;
                    r_qd <= {r_qd[MW-2:0], !td[MW]};
                    if (r_bit == '0) begin
                        r_state  <= ST_DONE;
                        r_fin_dz <= 1'b0;
                        r_fin_num <= r_neg ? -RES_NUM_WIDTH'(qn_last)
                                           : RES_NUM_WIDTH'(qn_last);
                        r_fin_den <= RES_DEN_WIDTH'({r_qd[MW-2:0], !td[MW]});
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register: loads a finished job, clears on a result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_res_num  <= r_fin_num;
            r_res_den  <= r_fin_den;
            r_div_zero <= r_fin_dz;
        end
    end

    assign empty      = !r_out_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_div_zero = r_div_zero;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> $stable(r_res_num) && $stable(r_res_den))
        else $error("result changed while waiting");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res_den != '0)
        else $error("zero result denominator");
    a_gcd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> (r_u != '0) && (r_v != '0))
        else $error("gcd operand reached zero");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_state != ST_IDLE)
        else $error("job taken but not started");
`endif
endmodule
